### rtl/ps2_mouse_packet_to_cursor_position_top_defines.svh
// Assertion helpers for the RTL, used by ps2mc_ctrl. They expect clk and rst_n in scope.
`ifndef PS2_MOUSE_PACKET_TO_CURSOR_POSITION_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_TO_CURSOR_POSITION_TOP_DEFINES_SVH

// same-cycle implication
`define PS2MC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PS2MC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ps2mc_pkg.sv
package ps2mc_pkg;

  localparam int unsigned POS_W  = 26;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 12;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SENS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCR_W = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCR_H = 3'd2;
  localparam logic [IDX_W-1:0] REG_CUR_W = 3'd3;
  localparam logic [IDX_W-1:0] REG_CUR_H = 3'd4;

  localparam logic [8:0]  SENS_MIN   = 9'd10;
  localparam logic [8:0]  SENS_MAX   = 9'd500;
  localparam logic [8:0]  SENS_RST   = 9'd120;
  localparam logic [6:0]  CUR_RST    = 7'd16;
  localparam logic [31:0] ACC_X_RST  = 32'd40000;
  localparam logic [31:0] ACC_Y_RST  = 32'd30000;

  localparam logic [7:0]        SYNC_MASK  = 8'h08;
  localparam logic signed [7:0] BIG_DELTA  = 8'sd5;

  // x/10 == (x * RECIP_K) >> RECIP_SH, exact for x < 2^20
  localparam logic [19:0] RECIP_K    = 20'd838861;
  localparam int unsigned RECIP_SH   = 23;

  // x/100 == (x * RECIP100_K) >> RECIP100_SH, exact for any 32-bit x
  localparam logic [31:0] RECIP100_K  = 32'd1374389535;
  localparam int unsigned RECIP100_SH = 37;

  typedef struct packed {
    logic load_set;
    logic cap_hdr;
    logic cap_dx;
    logic cap_dy;
    logic mul;
    logic scale;
    logic adj;
    logic div_init;
    logic div_step;
    logic finish;
  } ps2mc_cmd_t;

  typedef struct packed {
    logic is_set;
    logic is_aux;
    logic sync;
    logic out_free;
  } ps2mc_sts_t;

  typedef struct packed {
    logic               wr;
    logic signed [25:0] pos;
    logic [31:0]        acc;
  } ps2mc_clamp_t;

endpackage

### rtl/ps2mc_ifs.sv
interface ps2mc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [7:0]                data_byte;
  logic                      from_aux;
  logic signed [ps2mc_pkg::POS_W-1:0] set_x;
  logic signed [ps2mc_pkg::POS_W-1:0] set_y;

  modport source (output valid, cmd, data_byte, from_aux, set_x, set_y, input ready);
  modport sink   (input valid, cmd, data_byte, from_aux, set_x, set_y, output ready);
endinterface

interface ps2mc_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [ps2mc_pkg::POS_W-1:0] pos_x;
  logic signed [ps2mc_pkg::POS_W-1:0] pos_y;
  logic [2:0]                buttons;

  modport source (output valid, pos_x, pos_y, buttons, input ready);
  modport sink   (input valid, pos_x, pos_y, buttons, output ready);
endinterface

interface ps2mc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ps2mc_pkg::IDX_W-1:0]   index;
  logic [ps2mc_pkg::CFG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ps2mc_ctrl.sv
`include "ps2_mouse_packet_to_cursor_position_top_defines.svh"

module ps2mc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ps2mc_pkg::ps2mc_sts_t sts,
  output ps2mc_pkg::ps2mc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_ADJ   = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_DX  = 2'd1;
  localparam logic [1:0] PH_DY  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_set) begin
            cmd.load_set = 1'b1;
          end else if (sts.is_aux) begin
            case (phase_r)
              PH_DX: begin
                cmd.cap_dx = 1'b1;
                phase_nxt  = PH_DY;
              end
              PH_DY: begin
                cmd.cap_dy = 1'b1;
                phase_nxt  = PH_HDR;
                state_nxt  = S_MUL;
              end
              default: begin
                // header must carry the sync bit, otherwise drop and stay
                if (sts.sync) begin
                  cmd.cap_hdr = 1'b1;
                  phase_nxt   = PH_DX;
                end
              end
            endcase
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.adj   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HDR;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  `PS2MC_ASSERT_NEXT(a_div_ends, state_r == S_DIV, state_r == S_DONE, "divide did not finish in one step")
  `PS2MC_ASSERT_NOW(a_finish_free, cmd.finish, sts.out_free, "result written while output register busy")
  `PS2MC_ASSERT_NEXT(a_pkt_start, in_valid && in_ready && !sts.is_set && sts.is_aux && phase_r == PH_DY, state_r == S_MUL && phase_r == PH_HDR, "third byte did not start packet processing")
  `PS2MC_ASSERT_NOW(a_phase_valid, state_r != S_IDLE, phase_r == PH_HDR, "packet phase advanced during processing")

endmodule

### rtl/ps2mc_dp.sv
module ps2mc_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ps2mc_pkg::ps2mc_cmd_t     cmd,
  output ps2mc_pkg::ps2mc_sts_t     sts,
  input  logic                      in_cmd,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_from_aux,
  input  logic signed [25:0]        in_set_x,
  input  logic signed [25:0]        in_set_y,
  input  logic                      cfg_valid,
  input  logic [ps2mc_pkg::IDX_W-1:0] cfg_index,
  input  logic [ps2mc_pkg::CFG_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [25:0]        out_pos_x,
  output logic signed [25:0]        out_pos_y,
  output logic [2:0]                out_buttons
);

  // config
  logic [8:0]  sens_r;
  logic [11:0] scr_w_r, scr_h_r;
  logic [6:0]  cur_w_r, cur_h_r;

  // packet
  logic [7:0]  hdr_r, dx_r, dy_r;
  logic signed [31:0] acc_x_r, acc_y_r;

  // scaling
  logic signed [17:0] sx_r, sy_r;
  logic               big_r;
  logic [39:0]        prod_x_r, prod_y_r;
  logic               neg_sx_r, neg_sy_r;

  // divide by 100, both axes side by side
  logic [31:0] dv_x_r, dv_y_r;
  logic        neg_x_r, neg_y_r;

  logic               out_valid_r;
  logic signed [25:0] out_x_r, out_y_r;
  logic [2:0]         out_btn_r;

  assign sts.is_set   = in_cmd;
  assign sts.is_aux   = in_from_aux;
  assign sts.sync     = (in_data_byte & ps2mc_pkg::SYNC_MASK) != 8'd0;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_buttons = out_btn_r;

  // ---- config writes, sensitivity saturated to its legal range
  logic [8:0] sens_wr;
  always_comb begin
    sens_wr = cfg_data[8:0];
    if (sens_wr < ps2mc_pkg::SENS_MIN) sens_wr = ps2mc_pkg::SENS_MIN;
    if (sens_wr > ps2mc_pkg::SENS_MAX) sens_wr = ps2mc_pkg::SENS_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= ps2mc_pkg::SENS_RST;
      scr_w_r <= '0;
      scr_h_r <= '0;
      cur_w_r <= ps2mc_pkg::CUR_RST;
      cur_h_r <= ps2mc_pkg::CUR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ps2mc_pkg::REG_SENS:  sens_r  <= sens_wr;
        ps2mc_pkg::REG_SCR_W: scr_w_r <= cfg_data;
        ps2mc_pkg::REG_SCR_H: scr_h_r <= cfg_data;
        ps2mc_pkg::REG_CUR_W: cur_w_r <= cfg_data[6:0];
        ps2mc_pkg::REG_CUR_H: cur_h_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // ---- scaling arithmetic
  logic signed [7:0]  rx, ry;
  logic               big;
  logic signed [21:0] sx14, sy14;
  logic [19:0]        mag_x14, mag_y14;
  logic signed [17:0] adj_x, adj_y;
  logic [16:0]        q10_x, q10_y;
  logic signed [33:0] set_x100, set_y100;

  assign rx  = $signed(dx_r);
  assign ry  = $signed(dy_r);
  assign big = (rx > ps2mc_pkg::BIG_DELTA) || (rx < -ps2mc_pkg::BIG_DELTA) ||
               (ry > ps2mc_pkg::BIG_DELTA) || (ry < -ps2mc_pkg::BIG_DELTA);

  assign sx14 = 22'(sx_r) * 22'sd14;
  assign sy14 = 22'(sy_r) * 22'sd14;
  assign mag_x14 = sx14[21] ? 20'(-sx14) : sx14[19:0];
  assign mag_y14 = sy14[21] ? 20'(-sy14) : sy14[19:0];

  assign q10_x = prod_x_r[ps2mc_pkg::RECIP_SH +: 17];
  assign q10_y = prod_y_r[ps2mc_pkg::RECIP_SH +: 17];

  always_comb begin
    adj_x = sx_r;
    adj_y = sy_r;
    if (big_r) begin
      adj_x = neg_sx_r ? -$signed({1'b0, q10_x}) : $signed({1'b0, q10_x});
      adj_y = neg_sy_r ? -$signed({1'b0, q10_y}) : $signed({1'b0, q10_y});
    end
  end

  assign set_x100 = 34'(in_set_x) * 34'sd100;
  assign set_y100 = 34'(in_set_y) * 34'sd100;

  // ---- magnitude divided by 100 through a scaled reciprocal
  logic [63:0] qx_full, qy_full;
  assign qx_full = 64'(dv_x_r) * 64'(ps2mc_pkg::RECIP100_K);
  assign qy_full = 64'(dv_y_r) * 64'(ps2mc_pkg::RECIP100_K);

  // ---- clamp
  function automatic ps2mc_pkg::ps2mc_clamp_t clamp_axis(
    input logic signed [25:0] pos,
    input logic [11:0]        scr,
    input logic [6:0]         cur
  );
    logic signed [13:0] lim;
    logic signed [13:0] lm1;
    logic signed [21:0] lm100;
    logic signed [25:0] p;
    ps2mc_pkg::ps2mc_clamp_t r;
    lim   = $signed({2'b00, scr}) - $signed({7'd0, cur});
    lm1   = lim - 14'sd1;
    lm100 = 22'(lm1) * 22'sd100;
    p     = pos;
    r.wr  = 1'b0;
    r.acc = '0;
    if (p < 26'sd0) begin
      p    = '0;
      r.wr = 1'b1;
    end
    if (p >= 26'(lim)) begin
      p     = 26'(lm1);
      r.wr  = 1'b1;
      r.acc = 32'(lm100);
    end
    r.pos = p;
    return r;
  endfunction

  logic signed [25:0]      px, py;
  logic                    clamp_en;
  ps2mc_pkg::ps2mc_clamp_t cx, cy;

  assign px = neg_x_r ? -$signed(dv_x_r[25:0]) : $signed(dv_x_r[25:0]);
  assign py = neg_y_r ? -$signed(dv_y_r[25:0]) : $signed(dv_y_r[25:0]);
  assign clamp_en = (scr_w_r != 12'd0) && (scr_h_r != 12'd0);
  assign cx = clamp_axis(px, scr_w_r, cur_w_r);
  assign cy = clamp_axis(py, scr_h_r, cur_h_r);

  // ---- packet/accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= '0;
      dx_r    <= '0;
      acc_x_r <= ps2mc_pkg::ACC_X_RST;
      acc_y_r <= ps2mc_pkg::ACC_Y_RST;
    end else begin
      if (cmd.cap_hdr) hdr_r <= in_data_byte;
      if (cmd.cap_dx)  dx_r  <= in_data_byte;
      if (cmd.load_set) begin
        acc_x_r <= set_x100[31:0];
        acc_y_r <= set_y100[31:0];
      end else if (cmd.adj) begin
        acc_x_r <= acc_x_r + 32'(adj_x);
        acc_y_r <= acc_y_r - 32'(adj_y);
      end else if (cmd.finish && clamp_en) begin
        if (cx.wr) acc_x_r <= cx.acc;
        if (cy.wr) acc_y_r <= cy.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_dy) dy_r <= in_data_byte;
    if (cmd.mul) begin
      sx_r  <= 18'(rx * $signed({1'b0, sens_r}));
      sy_r  <= 18'(ry * $signed({1'b0, sens_r}));
      big_r <= big;
    end
    if (cmd.scale) begin
      prod_x_r <= 40'(mag_x14) * 40'(ps2mc_pkg::RECIP_K);
      prod_y_r <= 40'(mag_y14) * 40'(ps2mc_pkg::RECIP_K);
      neg_sx_r <= sx14[21];
      neg_sy_r <= sy14[21];
    end
    if (cmd.div_init) begin
      neg_x_r <= acc_x_r[31];
      neg_y_r <= acc_y_r[31];
      dv_x_r  <= acc_x_r[31] ? 32'(-acc_x_r) : acc_x_r;
      dv_y_r  <= acc_y_r[31] ? 32'(-acc_y_r) : acc_y_r;
    end else if (cmd.div_step) begin
      dv_x_r  <= 32'(qx_full >> ps2mc_pkg::RECIP100_SH);
      dv_y_r  <= 32'(qy_full >> ps2mc_pkg::RECIP100_SH);
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_x_r   <= clamp_en ? cx.pos : px;
      out_y_r   <= clamp_en ? cy.pos : py;
      out_btn_r <= hdr_r[2:0];
    end
  end

endmodule

### rtl/ps2_mouse_packet_to_cursor_position_top.sv
// PS/2 mouse packet decoder. Bytes not from the aux port, set-position
// commands and the first two bytes of a packet are each taken without
// holding the input. The third byte holds the input while the block steps
// through capture, scale by sensitivity, apply the 14/10 boost through a
// reciprocal multiply (only if a delta exceeds BIG_DELTA in magnitude) and
// update the accumulators, then the divide by 100 (take the magnitude, then
// a reciprocal multiply, both axes in parallel), then clamp (when both screen
// sizes are nonzero) and write the output register, waiting while that
// register still holds an untaken result. Input is accepted while a finished result waits.
// Configuration writes are always accepted; the cfg port is ready at all times.
module ps2_mouse_packet_to_cursor_position_top (
  input  logic                clk,
  input  logic                rst_n,
  ps2mc_in_if.sink            in_ch,
  ps2mc_out_if.source         out_ch,
  ps2mc_cfg_if.sink           cfg_ch
);

  ps2mc_pkg::ps2mc_cmd_t cmd;
  ps2mc_pkg::ps2mc_sts_t sts;
  logic                  in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  ps2mc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ps2mc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_cmd       (in_ch.cmd),
    .in_data_byte (in_ch.data_byte),
    .in_from_aux  (in_ch.from_aux),
    .in_set_x     (in_ch.set_x),
    .in_set_y     (in_ch.set_y),
    .cfg_valid    (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_pos_x    (out_ch.pos_x),
    .out_pos_y    (out_ch.pos_y),
    .out_buttons  (out_ch.buttons)
  );

endmodule
